@@ rtl/gcd_pkg.sv @@
// Shared constants and the arctangent table for the great-circle distance block.
`timescale 1ns / 1ps
package gcd_pkg;

  // angles in degrees with 17 fraction bits
  localparam int ANG_W = 27;
  localparam logic signed [ANG_W-1:0] DEG_FULL    = 27'sd47185920;
  localparam logic signed [ANG_W-1:0] DEG_HALF    = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] DEG_QUARTER = 27'sd11796480;

  // pi/180 * 2^43, split at bit 19
  localparam logic signed [19:0] D_HI = 20'sd292817;
  localparam logic signed [19:0] D_LO = 20'sd345253;

  // CORDIC datapath width (Q2.30 plus growth)
  localparam int CW = 34;
  localparam logic signed [CW-1:0] INV_GAIN = 34'sh026DD3B6A;

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [25:0] DIST_MAX = 26'd52706200;
  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  // atan(2^-i) in Q2.30, rounded to nearest
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    unique case (i)
      0: v = 32'd843314857;
      1: v = 32'd497837829;
      2: v = 32'd263043837;
      3: v = 32'd133525159;
      4: v = 32'd67021687;
      5: v = 32'd33543516;
      6: v = 32'd16775851;
      7: v = 32'd8388437;
      8: v = 32'd4194283;
      9: v = 32'd2097149;
      default: v = (i >= 31) ? 32'd1 : (32'd1 << (30 - i));
    endcase
    return v;
  endfunction

endpackage

@@ rtl/gcd_sincos.sv @@
// Four-lane angle reduction and rotation CORDIC: cosines of both latitudes, sines of half deltas.
`timescale 1ns / 1ps
module gcd_sincos #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [23:0] lat1,
  input  logic signed [24:0] lon1,
  input  logic signed [23:0] lat2,
  input  logic signed [24:0] lon2,
  output logic               out_valid,
  output logic signed [31:0] cos1,
  output logic signed [31:0] cos2,
  output logic signed [31:0] sin_dlat,
  output logic signed [31:0] sin_dlon
);

  localparam int AW = gcd_pkg::ANG_W;
  localparam int CW = gcd_pkg::CW;
  localparam int N  = CORDIC_STEPS;
  localparam logic signed [65:0] RND29 = 66'sd1 <<< 29;

  logic signed [AW-1:0] a_raw [4];
  logic signed [AW-1:0] ang   [4];
  logic signed [AW-1:0] fold  [4];
  logic                 flip2 [4];
  logic signed [46:0]   p_hi  [4];
  logic signed [46:0]   p_lo  [4];
  logic                 flip3 [4];
  logic signed [CW-1:0] z4    [4];
  logic                 flip4 [4];
  logic signed [CW-1:0] x_q   [4][N];
  logic signed [CW-1:0] y_q   [4][N];
  logic signed [CW-1:0] z_q   [4][N];
  logic                 f_q   [4][N];
  logic                 v1, v2, v3, v4;
  logic [N-1:0]         vc;

  // lane 0/1: latitudes, lane 2/3: half deltas
  always_comb begin
    a_raw[0] = {{2{lat1[23]}}, lat1, 1'b0};
    a_raw[1] = {{2{lat2[23]}}, lat2, 1'b0};
    a_raw[2] = AW'(lat2) - AW'(lat1);
    a_raw[3] = AW'(lon2) - AW'(lon1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic signed [65:0] zsum;
    assign zsum = (66'(p_hi[l]) <<< 19) + 66'(p_lo[l]) + RND29;

    always_ff @(posedge clk) begin
      if (en) begin
        // wrap into (-180, 180]
        if (a_raw[l] > gcd_pkg::DEG_HALF) begin
          ang[l] <= a_raw[l] - gcd_pkg::DEG_FULL;
        end else if (a_raw[l] <= -gcd_pkg::DEG_HALF) begin
          ang[l] <= a_raw[l] + gcd_pkg::DEG_FULL;
        end else begin
          ang[l] <= a_raw[l];
        end
        // fold into [-90, 90], cosine changes sign
        if (ang[l] > gcd_pkg::DEG_QUARTER) begin
          fold[l]  <= gcd_pkg::DEG_HALF - ang[l];
          flip2[l] <= 1'b1;
        end else if (ang[l] < -gcd_pkg::DEG_QUARTER) begin
          fold[l]  <= -gcd_pkg::DEG_HALF - ang[l];
          flip2[l] <= 1'b1;
        end else begin
          fold[l]  <= ang[l];
          flip2[l] <= 1'b0;
        end
        p_hi[l]  <= 47'(fold[l]) * 47'(gcd_pkg::D_HI);
        p_lo[l]  <= 47'(fold[l]) * 47'(gcd_pkg::D_LO);
        flip3[l] <= flip2[l];
        z4[l]    <= zsum[63:30];
        flip4[l] <= flip3[l];
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic signed [CW-1:0] ATAN = {2'b00, gcd_pkg::atan_q30(i)};
      logic signed [CW-1:0] xi, yi, zi;
      logic                 fi;
      if (i == 0) begin : g_first
        assign xi = gcd_pkg::INV_GAIN;
        assign yi = '0;
        assign zi = z4[l];
        assign fi = flip4[l];
      end else begin : g_next
        assign xi = x_q[l][i-1];
        assign yi = y_q[l][i-1];
        assign zi = z_q[l][i-1];
        assign fi = f_q[l][i-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (zi >= 0) begin
            x_q[l][i] <= xi - (yi >>> i);
            y_q[l][i] <= yi + (xi >>> i);
            z_q[l][i] <= zi - ATAN;
          end else begin
            x_q[l][i] <= xi + (yi >>> i);
            y_q[l][i] <= yi - (xi >>> i);
            z_q[l][i] <= zi + ATAN;
          end
          f_q[l][i] <= fi;
        end
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vc[i] <= 1'b0;
      end else if (en) begin
        vc[i] <= (i == 0) ? v4 : vc[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vc[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos1     <= f_q[0][N-1] ? 32'(-x_q[0][N-1]) : x_q[0][N-1][31:0];
      cos2     <= f_q[1][N-1] ? 32'(-x_q[1][N-1]) : x_q[1][N-1][31:0];
      sin_dlat <= y_q[2][N-1][31:0];
      sin_dlon <= y_q[3][N-1][31:0];
    end
  end

endmodule

@@ rtl/gcd_sqrt.sv @@
// Pipelined floor square root of a 61-bit value, one result bit per stage.
`timescale 1ns / 1ps
module gcd_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v,
  output logic [30:0] root
);

  localparam int NS = 31;

  logic [61:0] rem_q [NS];
  logic [61:0] res_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
    logic [61:0] rem_i, res_i, trial;
    if (j == 0) begin : g_first
      assign rem_i = {1'b0, v};
      assign res_i = '0;
    end else begin : g_next
      assign rem_i = rem_q[j-1];
      assign res_i = res_q[j-1];
    end
    assign trial = res_i + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_q[j] <= rem_i - trial;
          res_q[j] <= (res_i >> 1) + BIT;
        end else begin
          rem_q[j] <= rem_i;
          res_q[j] <= res_i >> 1;
        end
      end
    end
  end

  assign root = res_q[NS-1][30:0];

endmodule

@@ rtl/great_circle_distance.sv @@
// Top level: haversine great-circle distance pipeline.
`timescale 1ns / 1ps
// Great-circle distance between two points given as signed degrees
// (16 fraction bits). One request carries both points on the req_*
// channel; one result, the distance in km with 8 fraction bits, leaves
// on the dist_* channel. A request is taken when req_valid is high and
// req_stall is low; a result is taken when dist_valid is high and
// dist_stall is low.
// Throughput: one request per cycle while req_stall is low. The depth
// is set by the two unrolled CORDIC chains (one stage per iteration)
// and the 31-stage square-root pipeline.
// The user writes the radius register (whole km, cfg_wr_en/cfg_wr_data)
// only while the pipeline is empty; the block does not enforce it.
// Reset loads 6371, clears every valid bit; the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline
// holds in place and req_stall rises; nothing is dropped or repeated.
module great_circle_distance #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic signed [23:0] first_latitude,
  input  logic signed [24:0] first_longitude,
  input  logic signed [23:0] second_latitude,
  input  logic signed [24:0] second_longitude,
  output logic               dist_valid,
  input  logic               dist_stall,
  output logic [25:0]        distance,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  localparam int CW = gcd_pkg::CW;
  localparam int N  = CORDIC_STEPS;
  localparam int SQ = 31;
  localparam logic signed [63:0] RND29 = 64'sd1 <<< 29;
  localparam logic [46:0] RND20 = 47'd1 << 20;

  logic        adv;
  logic [15:0] radius;

  logic               sc_valid;
  logic signed [31:0] c1, c2, s1, s2;

  logic signed [63:0] pr_ss1, pr_cc, pr_ss2, pr_t;
  logic signed [31:0] p1_ss1, p1_cc, p1_ss2;
  logic signed [31:0] p2_ss1, p2_t;
  logic signed [32:0] h_sum;
  logic [30:0]        p3_h;
  logic               p1_v, p2_v, p3_v;

  logic [SQ-1:0] sq_v;
  logic [30:0]   root_y, root_x;
  logic [30:0]   one_minus_h;

  logic signed [CW-1:0] vx_q [N];
  logic signed [CW-1:0] vy_q [N];
  logic signed [CW-1:0] vz_q [N];
  logic [N-1:0]         vv;

  logic [30:0] z_clamp;
  logic [46:0] m_prod;
  logic        m_v;
  logic [46:0] d_sum;
  logic [26:0] d_full;

  // whole pipeline moves unless a finished result is held back
  assign adv       = !dist_valid || !dist_stall;
  assign req_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  gcd_sincos #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_sincos (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (req_valid),
    .lat1     (first_latitude),
    .lon1     (first_longitude),
    .lat2     (second_latitude),
    .lon2     (second_longitude),
    .out_valid(sc_valid),
    .cos1     (c1),
    .cos2     (c2),
    .sin_dlat (s1),
    .sin_dlon (s2)
  );

  // haversine terms, each product rounded back to Q30
  assign pr_ss1 = 64'(s1) * 64'(s1) + RND29;
  assign pr_cc  = 64'(c1) * 64'(c2) + RND29;
  assign pr_ss2 = 64'(s2) * 64'(s2) + RND29;
  assign pr_t   = 64'(p1_cc) * 64'(p1_ss2) + RND29;
  assign h_sum  = 33'(p2_ss1) + 33'(p2_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else if (adv) begin
      p1_v <= sc_valid;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ss1 <= pr_ss1[61:30];
      p1_cc  <= pr_cc[61:30];
      p1_ss2 <= pr_ss2[61:30];
      p2_ss1 <= p1_ss1;
      p2_t   <= pr_t[61:30];
      // clamp h to [0, 1]
      if (h_sum < 0) begin
        p3_h <= '0;
      end else if (h_sum > 33'(gcd_pkg::Q30_ONE)) begin
        p3_h <= gcd_pkg::Q30_ONE;
      end else begin
        p3_h <= h_sum[30:0];
      end
    end
  end

  // sqrt(h) and sqrt(1-h) in Q30
  assign one_minus_h = gcd_pkg::Q30_ONE - p3_h;

  gcd_sqrt u_sqrt_y (
    .clk (clk),
    .en  (adv),
    .v   ({p3_h, 30'd0}),
    .root(root_y)
  );

  gcd_sqrt u_sqrt_x (
    .clk (clk),
    .en  (adv),
    .v   ({one_minus_h, 30'd0}),
    .root(root_x)
  );

  for (genvar j = 0; j < SQ; j++) begin : g_sq_valid
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j] <= 1'b0;
      end else if (adv) begin
        sq_v[j] <= (j == 0) ? p3_v : sq_v[(j == 0) ? 0 : j-1];
      end
    end
  end

  // vectoring CORDIC: central half-angle = atan2(sqrt(h), sqrt(1-h))
  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [CW-1:0] ATAN = {2'b00, gcd_pkg::atan_q30(i)};
    logic signed [CW-1:0] xi, yi, zi;
    logic                 vi;
    if (i == 0) begin : g_first
      assign xi = CW'(root_x);
      assign yi = CW'(root_y);
      assign zi = '0;
      assign vi = sq_v[SQ-1];
    end else begin : g_next
      assign xi = vx_q[i-1];
      assign yi = vy_q[i-1];
      assign zi = vz_q[i-1];
      assign vi = vv[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i] <= 1'b0;
      end else if (adv) begin
        vv[i] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (yi >= 0) begin
          vx_q[i] <= xi + (yi >>> i);
          vy_q[i] <= yi - (xi >>> i);
          vz_q[i] <= zi + ATAN;
        end else begin
          vx_q[i] <= xi - (yi >>> i);
          vy_q[i] <= yi + (xi >>> i);
          vz_q[i] <= zi - ATAN;
        end
      end
    end
  end

  // scale by radius: 2*z*R with 8 fraction bits, rounded, saturated
  assign z_clamp = (vz_q[N-1] < 0) ? '0 : vz_q[N-1][30:0];
  assign d_sum   = m_prod + RND20;
  assign d_full  = d_sum[46:20] >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v        <= 1'b0;
      dist_valid <= 1'b0;
    end else if (adv) begin
      m_v        <= vv[N-1];
      dist_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_prod <= 47'(z_clamp) * 47'(radius);
      if (d_full > 27'(gcd_pkg::DIST_MAX)) begin
        distance <= gcd_pkg::DIST_MAX;
      end else begin
        distance <= d_full[25:0];
      end
    end
  end

endmodule
